>>> hdl/pfd_pkg.sv
package pfd_pkg;

    localparam int unsigned DATA_W      = 31;
    localparam int unsigned CFG_W       = 4;
    localparam int unsigned TDATA_W     = 32;
    localparam int unsigned MAX_DIM_DEF = 8;

    localparam logic [DATA_W-1:0] PRIME   = 31'd2013265921;
    localparam logic [DATA_W-1:0] INV_EXP = 31'd2013265919;

endpackage

>>> hdl/prime_field_determinant.sv
// determinant of an m by m matrix modulo the prime 2013265921
//
// channels: s_axis carries one matrix entry per item in row-major order,
// m_axis one determinant item per completed matrix. the size m (1..MAX_DIM,
// 0 acts as 1, larger values saturate) is set via i_cfg_we / i_cfg_wdata, by
// the user only while idle (unchecked by the block); a write restarts loading.
//
// an entry is taken and stored in a single-port-read ram. on the last entry
// the block goes busy (s_axis_tready low) and runs elimination with one
// bit-serial modular multiplier. each column costs the pivot search and swap,
// the pivot inversion (61 products) and the row updates; a singular matrix
// stops at the first column without pivot.
//
// the result sits in an output register until taken; loading of the next
// matrix may start meanwhile, and the next result waits if still unread.
// reset (synchronous, active low) sets m to MAX_DIM and clears loading and
// the output valid; matrix contents are not cleared.
module prime_field_determinant
    #(
    parameter int unsigned MAX_DIM = pfd_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pfd_pkg::CFG_W-1:0]   i_cfg_wdata,    // matrix_size
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [pfd_pkg::TDATA_W-1:0] s_axis_tdata,   // entry_value[30:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [pfd_pkg::TDATA_W-1:0] m_axis_tdata    // determinant[30:0]
);
    import pfd_pkg::*;

    localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned DW    = $clog2(MAX_DIM + 1);
    localparam int unsigned DEPTH = (MAX_DIM > 1) ? MAX_DIM * MAX_DIM : 2;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_SW_RD1, S_SW_RD2, S_SW_WR1, S_SW_WR2,
        S_PV_RD, S_PV_DAT, S_DETM, S_INV_SQ, S_INV_SQD, S_INV_MLD, S_INV_NX,
        S_EL_RD, S_EL_LD, S_EL_F, S_EC_RD1, S_EC_MUL, S_EC_RD2, S_EC_WR,
        S_MUL, S_DONE
    } t_state;

    t_state r_state, r_ret;

    logic [DW-1:0]     r_m;
    logic [IW-1:0]     r_r, r_c, r_k, r_p;
    logic [DATA_W-1:0] r_det, r_piv, r_inv, r_f, r_t, r_out;
    logic [DATA_W-1:0] r_ma, r_mb, r_acc;
    logic [4:0]        r_mcnt, r_bit;
    logic              r_ovalid;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;
    logic [DATA_W-1:0] in_val, in_red, sub_res, mul_next;
    logic [32:0]       mul_t;
    logic [DW-1:0]     cfg_sat;
    logic              accept;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
        return AW'(row * MAX_DIM + col);
    endfunction

    function automatic logic f_last(input logic [IW-1:0] x, input logic [DW-1:0] m);
        return (DW'(x) + 1'b1) == m;
    endfunction

    assign in_val  = s_axis_tdata[DATA_W-1:0];
    assign in_red  = (in_val >= PRIME) ? in_val - PRIME : in_val;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign sub_res = (rdata >= r_acc) ? rdata - r_acc
                                      : DATA_W'({1'b0, rdata} + {1'b0, PRIME} - {1'b0, r_acc});

    // one bit of the multiplier operand per cycle, msb first
    assign mul_t = {1'b0, r_acc, 1'b0} + (r_mb[r_mcnt] ? {2'b00, r_ma} : 33'd0);
    always_comb begin
        if (mul_t >= {1'b0, PRIME, 1'b0}) begin
            mul_next = DATA_W'(mul_t - {1'b0, PRIME, 1'b0});
        end else if (mul_t >= {2'b00, PRIME}) begin
            mul_next = DATA_W'(mul_t - {2'b00, PRIME});
        end else begin
            mul_next = DATA_W'(mul_t);
        end
    end

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_sat = DW'(1);
        end else if (32'(i_cfg_wdata) > MAX_DIM) begin
            cfg_sat = DW'(MAX_DIM);
        end else begin
            cfg_sat = DW'(i_cfg_wdata);
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = f_addr(r_r, r_c);
        wdata = in_red;
        raddr = f_addr(r_r, r_k);
        case (r_state)
            S_IDLE:   we = accept;
            S_SW_RD1: raddr = f_addr(r_p, r_c);
            S_SW_RD2: raddr = f_addr(r_k, r_c);
            S_SW_WR1: begin
                we    = 1'b1;
                waddr = f_addr(r_p, r_c);
                wdata = rdata;
            end
            S_SW_WR2: begin
                we    = 1'b1;
                waddr = f_addr(r_k, r_c);
                wdata = r_t;
            end
            S_PV_RD:  raddr = f_addr(r_k, r_k);
            S_EC_RD1: raddr = f_addr(r_k, r_c);
            S_EC_RD2: raddr = f_addr(r_r, r_c);
            S_EC_WR: begin
                we    = 1'b1;
                wdata = sub_res;
            end
            default: ;
        endcase
    end

    pfd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_m      <= DW'(MAX_DIM);
            r_r      <= '0;
            r_c      <= '0;
            r_k      <= '0;
            r_det    <= DATA_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (f_last(r_c, r_m)) begin
                            r_c <= '0;
                            if (f_last(r_r, r_m)) begin
                                r_r     <= '0;
                                r_k     <= '0;
                                r_state <= S_SRCH_RD;
                            end else begin
                                r_r <= r_r + 1'b1;
                            end
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                end
                S_SRCH_RD: r_state <= S_SRCH_CHK;
                S_SRCH_CHK: begin
                    if (rdata != '0) begin
                        r_p <= r_r;
                        r_c <= '0;
                        r_state <= (r_r != r_k) ? S_SW_RD1 : S_PV_RD;
                    end else if (f_last(r_r, r_m)) begin
                        r_det   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_r     <= r_r + 1'b1;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SW_RD1: r_state <= S_SW_RD2;
                S_SW_RD2: begin
                    r_t     <= rdata;
                    r_state <= S_SW_WR1;
                end
                S_SW_WR1: r_state <= S_SW_WR2;
                S_SW_WR2: begin
                    if (f_last(r_c, r_m)) begin
                        r_det   <= (r_det == '0) ? '0 : PRIME - r_det;
                        r_state <= S_PV_RD;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_SW_RD1;
                    end
                end
                S_PV_RD: r_state <= S_PV_DAT;
                S_PV_DAT: begin
                    r_piv   <= rdata;
                    r_ma    <= r_det;
                    r_mb    <= rdata;
                    r_acc   <= '0;
                    r_mcnt  <= 5'(DATA_W - 1);
                    r_ret   <= S_DETM;
                    r_state <= S_MUL;
                end
                S_DETM: begin
                    r_det   <= r_acc;
                    r_inv   <= DATA_W'(1);
                    r_bit   <= 5'(DATA_W - 1);
                    r_state <= S_INV_SQ;
                end
                S_INV_SQ: begin
                    r_ma    <= r_inv;
                    r_mb    <= r_inv;
                    r_acc   <= '0;
                    r_mcnt  <= 5'(DATA_W - 1);
                    r_ret   <= S_INV_SQD;
                    r_state <= S_MUL;
                end
                S_INV_SQD: begin
                    r_inv <= r_acc;
                    if (INV_EXP[r_bit]) begin
                        r_ma    <= r_acc;
                        r_mb    <= r_piv;
                        r_acc   <= '0;
                        r_mcnt  <= 5'(DATA_W - 1);
                        r_ret   <= S_INV_MLD;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_INV_NX;
                    end
                end
                S_INV_MLD: begin
                    r_inv   <= r_acc;
                    r_state <= S_INV_NX;
                end
                S_INV_NX: begin
                    if (r_bit == '0) begin
                        if (f_last(r_k, r_m)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_r     <= r_k + 1'b1;
                            r_state <= S_EL_RD;
                        end
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= S_INV_SQ;
                    end
                end
                S_EL_RD: r_state <= S_EL_LD;
                S_EL_LD: begin
                    if (rdata != '0) begin
                        r_ma    <= rdata;
                        r_mb    <= r_inv;
                        r_acc   <= '0;
                        r_mcnt  <= 5'(DATA_W - 1);
                        r_ret   <= S_EL_F;
                        r_state <= S_MUL;
                    end else if (f_last(r_r, r_m)) begin
                        r_k     <= r_k + 1'b1;
                        r_r     <= r_k + 1'b1;
                        r_state <= S_SRCH_RD;
                    end else begin
                        r_r     <= r_r + 1'b1;
                        r_state <= S_EL_RD;
                    end
                end
                S_EL_F: begin
                    r_f     <= r_acc;
                    r_c     <= r_k;
                    r_state <= S_EC_RD1;
                end
                S_EC_RD1: r_state <= S_EC_MUL;
                S_EC_MUL: begin
                    r_ma    <= r_f;
                    r_mb    <= rdata;
                    r_acc   <= '0;
                    r_mcnt  <= 5'(DATA_W - 1);
                    r_ret   <= S_EC_RD2;
                    r_state <= S_MUL;
                end
                S_EC_RD2: r_state <= S_EC_WR;
                S_EC_WR: begin
                    if (!f_last(r_c, r_m)) begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_EC_RD1;
                    end else if (f_last(r_r, r_m)) begin
                        r_k     <= r_k + 1'b1;
                        r_r     <= r_k + 1'b1;
                        r_state <= S_SRCH_RD;
                    end else begin
                        r_r     <= r_r + 1'b1;
                        r_state <= S_EL_RD;
                    end
                end
                S_MUL: begin
                    r_acc <= mul_next;
                    if (r_mcnt == '0) begin
                        r_state <= r_ret;
                    end else begin
                        r_mcnt <= r_mcnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out    <= r_det;
                        r_ovalid <= 1'b1;
                        r_det    <= DATA_W'(1);
                        r_r      <= '0;
                        r_c      <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we) begin
                r_m <= cfg_sat;
                r_r <= '0;
                r_c <= '0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(TDATA_W - DATA_W){1'b0}}, r_out};

endmodule

>>> hdl/pfd_ram.sv
module pfd_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/pfd_check.sv
module pfd_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [pfd_pkg::TDATA_W-1:0] m_axis_tdata
);
    import pfd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DATA_W-1:0] < PRIME && m_axis_tdata[TDATA_W-1] == 1'b0)
        else $error("determinant not reduced");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not clear the block");

    a_new_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without elimination");

endmodule

bind prime_field_determinant pfd_check u_pfd_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
